@@ sv/stream_pattern_masker_core_defines.svh @@
// assertion macros shared by the masker rtl
`ifndef STREAM_PATTERN_MASKER_CORE_DEFINES_SVH
`define STREAM_PATTERN_MASKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spm assertion failed");
// next-cycle implication
`define SPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spm assertion failed");
`else
`define SPM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ sv/spm_pkg.sv @@
package spm_pkg;

   // pattern register layout
   localparam int PAT_BYTES = 8;
   localparam int PAT_IDX_W = 3;

   // replacement byte for a matched pattern
   localparam logic [7:0] STAR_BYTE = 8'd42;

   // register file decode, registers 8 bytes apart
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_SEL_BIT = 3;
   localparam logic CSR_IDX_PATTERN = 1'b0;
   localparam logic CSR_IDX_LENGTH = 1'b1;

   // one input word handed to the window logic
   typedef struct packed {
      logic       advance;
      logic       line_end;
      logic [7:0] in_byte;
   } spm_step_type;

endpackage

@@ sv/spm_window.sv @@
`include "stream_pattern_masker_core_defines.svh"

module spm_window #(
   parameter int MAX_PATTERN = 8,
   localparam int CNT_W = $clog2(MAX_PATTERN + 1),
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spm_pkg::spm_step_type       step,
   input  logic [63:0]                 pattern_bytes,
   input  logic [3:0]                  pattern_length,
   output logic [CNT_W-1:0]            emit_count,
   output logic [MAX_PATTERN-1:0][7:0] emit_bytes
);
   import spm_pkg::*;

   logic [MAX_PATTERN-1:0][7:0] win_ff;
   logic [MAX_PATTERN-1:0][7:0] win_in;
   logic [CNT_W-1:0]            fill_ff;
   logic [CNT_W-1:0]            fill_in;

   logic [MAX_PATTERN-1:0][7:0] cat;
   logic [CNT_W-1:0]            len_eff;
   logic [CNT_W-1:0]            n_cnt;
   logic [CNT_W-1:0]            pop_cnt;
   logic [CNT_W-1:0]            k_cnt;
   logic                        match;
   logic                        full;
   logic [CNT_W-1:0]            icnt;
   logic [PAT_IDX_W-1:0]        pidx;
   logic [CNT_W:0]              src_sum;

   // effective length, clamped to the window depth
   always_comb begin
      if (pattern_length > 4'(MAX_PATTERN)) begin
         len_eff = CNT_W'(MAX_PATTERN);
      end else begin
         len_eff = pattern_length[CNT_W-1:0];
      end
   end

   // window with the new byte appended, and how many leave from the front
   always_comb begin
      n_cnt = CNT_W'(fill_ff + 1'b1);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         cat[i] = (CNT_W'(i) == fill_ff) ? step.in_byte : win_ff[i];
      end
      pop_cnt = (n_cnt > len_eff) ? CNT_W'(n_cnt - len_eff) : '0;
      full = (len_eff != '0) && (n_cnt >= len_eff);
   end

   // compare the last len_eff bytes against the pattern
   always_comb begin
      match = full;
      icnt = '0;
      pidx = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         icnt = CNT_W'(i);
         pidx = PAT_IDX_W'(icnt - pop_cnt);
         if ((icnt >= pop_cnt) && (icnt < n_cnt) &&
             (cat[i] != pattern_bytes[8*pidx +: 8])) begin
            match = 1'b0;
         end
      end
   end

   // words released by this byte
   always_comb begin
      if (step.line_end || match) begin
         k_cnt = n_cnt;
      end else if (full) begin
         k_cnt = CNT_W'(pop_cnt + 1'b1);
      end else begin
         k_cnt = pop_cnt;
      end
      emit_count = k_cnt;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         emit_bytes[i] = (match && (CNT_W'(i) >= pop_cnt)) ? STAR_BYTE : cat[i];
      end
   end

   // remaining bytes move to the front of the window
   always_comb begin
      fill_in = CNT_W'(n_cnt - k_cnt);
      src_sum = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         src_sum = (CNT_W+1)'(j) + (CNT_W+1)'(k_cnt);
         if (src_sum < (CNT_W+1)'(MAX_PATTERN)) begin
            win_in[j] = cat[src_sum[IDX_W-1:0]];
         end else begin
            win_in[j] = cat[j];
         end
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (step.advance) begin
         fill_ff <= fill_in;
      end
   end

   // pending bytes
   always_ff @(posedge clock) begin
      if (step.advance) begin
         win_ff <= win_in;
      end
   end

   `SPM_ASSERT_IMP(a_fill_below_depth, clock, reset, 1'b1, fill_ff < CNT_W'(MAX_PATTERN))
   `SPM_ASSERT_NEXT(a_line_end_empties, clock, reset, step.advance && step.line_end, fill_ff == '0)
   `SPM_ASSERT_IMP(a_emit_within_window, clock, reset, step.advance, emit_count <= n_cnt)

endmodule

@@ sv/stream_pattern_masker_core.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_in_byte, req_line_end
// rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_run_last, rsp_line_done
// csr     | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// an input word is registered in the input register, then the window logic turns it into 0 to
// MAX_PATTERN result words held in the result buffer; the first word is valid once the result
// buffer is loaded and can be taken from then on
// the result buffer sends one word a cycle while rsp_stall is low, so an input word that
// releases k words holds the next input word in the input register until its last word is
// taken; words that release none pass at one a cycle while the result buffer is empty
// reset empties the window and both buffers and clears the pattern and its length
// (length zero passes every byte through); rsp_stall freezes the buffer, and req_stall
// rises only while the input register waits for the result buffer
`include "stream_pattern_masker_core_defines.svh"

module stream_pattern_masker_core #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_line_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_run_last,
   output logic                             rsp_line_done,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [spm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [63:0]                      pwdata,
   output logic [63:0]                      prdata,
   output logic                             pready
);
   import spm_pkg::*;

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // configuration registers
   logic [63:0] pattern_ff;
   logic [3:0]  len_ff;
   logic        csr_write;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;
   logic        req_accept;
   logic        advance;

   // result buffer
   logic                        busy_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [IDX_W-1:0]            rd_ff;
   logic                        end_ff;
   logic [MAX_PATTERN-1:0][7:0] obuf_ff;
   logic                        rsp_take;
   logic                        last_entry;
   logic                        buf_free;

   spm_step_type                step;
   logic [CNT_W-1:0]            emit_count;
   logic [MAX_PATTERN-1:0][7:0] emit_bytes;

   // register write and read
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         len_ff <= '0;
      end else if (csr_write) begin
         case (paddr[CSR_SEL_BIT])
            CSR_IDX_PATTERN: pattern_ff <= pwdata;
            CSR_IDX_LENGTH:  len_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_SEL_BIT])
         CSR_IDX_PATTERN: prdata = pattern_ff;
         CSR_IDX_LENGTH:  prdata = {60'd0, len_ff};
         default:         prdata = '0;
      endcase
   end

   // output side handshake
   assign rsp_valid = busy_ff;
   assign rsp_take = busy_ff && !rsp_stall;
   assign last_entry = ((CNT_W'(rd_ff) + CNT_W'(1)) == cnt_ff);
   assign buf_free = !busy_ff || (rsp_take && last_entry);
   assign rsp_out_byte = obuf_ff[rd_ff];
   assign rsp_run_last = last_entry;
   assign rsp_line_done = last_entry && end_ff;

   // input side handshake
   assign advance = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_in_byte;
         in_end_ff <= req_line_end;
      end
   end

   // window and match logic
   assign step = '{advance: advance, line_end: in_end_ff, in_byte: in_byte_ff};

   spm_window #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .pattern_bytes (pattern_ff),
      .pattern_length(len_ff),
      .emit_count    (emit_count),
      .emit_bytes    (emit_bytes)
   );

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rd_ff <= '0;
      end else if (advance) begin
         busy_ff <= (emit_count != '0);
         rd_ff <= '0;
      end else if (rsp_take) begin
         if (last_entry) begin
            busy_ff <= 1'b0;
         end else begin
            rd_ff <= IDX_W'(rd_ff + 1'b1);
         end
      end
   end

   // result buffer data
   always_ff @(posedge clock) begin
      if (advance) begin
         cnt_ff <= emit_count;
         end_ff <= in_end_ff;
         obuf_ff <= emit_bytes;
      end
   end

   `SPM_ASSERT_IMP(a_read_in_range, clock, reset, busy_ff, CNT_W'(rd_ff) < cnt_ff)
   `SPM_ASSERT_NEXT(a_drain_continues, clock, reset, rsp_take && !last_entry, busy_ff)
   `SPM_ASSERT_NEXT(a_accept_loads, clock, reset, req_accept, in_valid_ff)

endmodule

@@ tb/testbench.sv @@
module testbench;

   // register byte addresses, registers lie 8 bytes apart
   localparam logic [spm_pkg::CSR_ADDR_W-1:0] REG_PATTERN =
      spm_pkg::CSR_ADDR_W'(spm_pkg::CSR_IDX_PATTERN) << spm_pkg::CSR_SEL_BIT;
   localparam logic [spm_pkg::CSR_ADDR_W-1:0] REG_LENGTH =
      spm_pkg::CSR_ADDR_W'(spm_pkg::CSR_IDX_LENGTH) << spm_pkg::CSR_SEL_BIT;
   localparam int WINDOW_MAX = spm_pkg::PAT_BYTES;
   localparam int SETTLE_CYCLES = 8;
   localparam int STUCK_LIMIT = 5000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_WORDS = 15;

   typedef struct packed {
      logic [7:0] text;
      logic       run_last;
      logic       line_done;
   } masked_word_type;

   // tracks pending text and the expected masked words
   class redaction_scoreboard;
      logic [7:0]      pending_text [WINDOW_MAX];
      int unsigned     pending_count;
      logic [63:0]     pattern;
      logic [3:0]      pattern_len;
      masked_word_type expected_words [$];
      int unsigned     fails;

      function new();
         pending_count = 0;
         pattern = '0;
         pattern_len = '0;
         fails = 0;
      endfunction

      function int unsigned active_len();
         return (pattern_len > WINDOW_MAX) ? WINDOW_MAX : pattern_len;
      endfunction

      // send the oldest pending byte unchanged
      function void release_oldest();
         expected_words.push_back('{text: pending_text[0], run_last: 1'b0, line_done: 1'b0});
         for (int i = 0; i < WINDOW_MAX - 1; i++) begin
            pending_text[i] = pending_text[i + 1];
         end
         pending_count--;
      endfunction

      function void note_byte(logic [7:0] text, logic line_end);
         int unsigned first;
         int unsigned len;
         bit hit;
         first = expected_words.size();
         len = active_len();
         pending_text[pending_count] = text;
         pending_count++;
         // a lowered length first pushes out the excess
         while (pending_count > len) begin
            release_oldest();
         end
         // full window: mask it or let the oldest go
         if (len > 0 && pending_count == len) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
               if (pending_text[k] != pattern[8 * k +: 8]) hit = 1'b0;
            end
            if (hit) begin
               for (int k = 0; k < len; k++) begin
                  expected_words.push_back('{text: spm_pkg::STAR_BYTE, run_last: 1'b0,
                                             line_done: 1'b0});
               end
               pending_count = 0;
            end else begin
               release_oldest();
            end
         end
         // end of line flushes the tail unmasked
         if (line_end) begin
            while (pending_count > 0) begin
               release_oldest();
            end
         end
         if (expected_words.size() > first) begin
            expected_words[expected_words.size() - 1].run_last = 1'b1;
            if (line_end) expected_words[expected_words.size() - 1].line_done = 1'b1;
         end
      endfunction

      function void check_word(logic [7:0] text, logic run_last, logic line_done);
         masked_word_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected word: out_byte %0d run_last %0d line_done %0d",
                   text, run_last, line_done);
            fails++;
            return;
         end
         want = expected_words.pop_front();
         if (text !== want.text) begin
            $error("out_byte mismatch: expected %0d, actual %0d", want.text, text);
            fails++;
         end
         if (run_last !== want.run_last) begin
            $error("run_last mismatch: expected %0d, actual %0d", want.run_last, run_last);
            fails++;
         end
         if (line_done !== want.line_done) begin
            $error("line_done mismatch: expected %0d, actual %0d", want.line_done, line_done);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_line_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [spm_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   redaction_scoreboard sb;
   bit          quiet_sender = 1'b0;
   int unsigned stuck_cycles = 0;

   stream_pattern_masker_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_line_end(req_line_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_line_done(rsp_line_done),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // send one text word, called and returning at a falling edge
   task automatic send_word(input logic [7:0] text, input logic line_end);
      int unsigned gap;
      gap = quiet_sender ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = text;
      req_line_end = line_end;
      do @(posedge clock); while (req_stall);
      sb.note_byte(text, line_end);
      @(negedge clock);
   endtask

   // wait until every expected word is out and the block has settled
   task automatic drain_words();
      req_valid = 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic write_csr(input logic [spm_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [63:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == REG_PATTERN) sb.pattern = value;
      else if (addr == REG_LENGTH) sb.pattern_len = value[3:0];
      @(negedge clock);
      // the register reads back what was written
      if (addr == REG_PATTERN && prdata !== value) begin
         $error("pattern_bytes mismatch: expected %0h, actual %0h", value, prdata);
         sb.fails++;
      end else if (addr == REG_LENGTH && prdata !== {60'd0, value[3:0]}) begin
         $error("pattern_length mismatch: expected %0d, actual %0d", value[3:0], prdata);
         sb.fails++;
      end
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // either random bytes or a two-letter alphabet that overlaps itself
   function automatic logic [63:0] pick_pattern();
      logic [63:0] value;
      if ($urandom_range(0, 2) == 0) begin
         value = {$urandom, $urandom};
      end else begin
         for (int k = 0; k < WINDOW_MAX; k++) begin
            value[8 * k +: 8] = 8'(8'h61 + $urandom_range(0, 1));
         end
      end
      return value;
   endfunction

   // a stretch of text rich in whole and broken pattern copies
   task automatic send_text(input int unsigned count, input bit close_line);
      logic [7:0] line [$];
      logic [7:0] text;
      int unsigned len;
      int unsigned pick;
      int unsigned cut;
      len = sb.active_len();
      while (line.size() < count) begin
         pick = $urandom_range(0, 9);
         if (len > 0 && pick < 4) begin
            for (int k = 0; k < len; k++) line.push_back(sb.pattern[8 * k +: 8]);
         end else if (len > 1 && pick < 6) begin
            cut = $urandom_range(1, len - 1);
            for (int k = 0; k < cut; k++) line.push_back(sb.pattern[8 * k +: 8]);
            line.push_back(8'($urandom_range(1, 255)));
         end else if (pick < 8) begin
            line.push_back(sb.pattern[8 * $urandom_range(0, WINDOW_MAX - 1) +: 8]);
         end else begin
            line.push_back(8'($urandom_range(1, 255)));
         end
      end
      for (int i = 0; i < count; i++) begin
         text = (line[i] == 8'h00) ? 8'h01 : line[i];
         send_word(text, close_line && (i == count - 1));
      end
   endtask

   // result side stall
   initial begin
      int unsigned open_run;
      int unsigned hold_run;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         open_run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         rsp_stall = 1'b0;
         repeat (open_run) @(negedge clock);
         hold_run = idle_gap();
         if (hold_run > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_run) @(negedge clock);
         end
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word(rsp_out_byte, rsp_run_last, rsp_line_done);
      end
   end

   // count cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_lengths [PHASE_COUNT];
      int unsigned sent;
      int unsigned count;
      sb = new();
      phase_lengths = '{1, 3, 8, 0, 15, 2, 5, 9, 4, 8};
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // pass-through after reset
      send_word(8'h01, 1'b0);
      send_word(8'hFF, 1'b1);

      // two-byte pattern, a near miss, a hit and an unmasked tail
      drain_words();
      write_csr(REG_PATTERN, 64'h0000_0000_0000_6261);
      write_csr(REG_LENGTH, 64'd2);
      send_word(8'h61, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(8'h61, 1'b1);

      // longest pattern of all-ones bytes
      drain_words();
      write_csr(REG_PATTERN, {64{1'b1}});
      write_csr(REG_LENGTH, 64'd8);
      for (int i = 0; i < 8; i++) send_word(8'hFF, 1'b0);
      send_word(8'h01, 1'b1);

      // pattern of zero bytes never matches text
      drain_words();
      write_csr(REG_PATTERN, 64'd0);
      write_csr(REG_LENGTH, 64'd1);
      send_word(8'h80, 1'b1);

      // length lowered while bytes are pending
      drain_words();
      write_csr(REG_PATTERN, 64'h0807_0605_0403_0201);
      write_csr(REG_LENGTH, 64'd8);
      for (int i = 1; i <= 5; i++) send_word(8'(i), 1'b0);
      drain_words();
      write_csr(REG_LENGTH, 64'd2);
      send_word(8'h07, 1'b1);

      // random phases, a phase may end in the middle of a line
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_words();
         write_csr(REG_PATTERN, pick_pattern());
         write_csr(REG_LENGTH, 64'(phase_lengths[p]));
         quiet_sender = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            count = $urandom_range(1, 12);
            if (count > PHASE_WORDS - sent) count = PHASE_WORDS - sent;
            send_text(count, $urandom_range(0, 3) != 0);
            sent += count;
         end
      end

      drain_words();
      if (sb.fails == 0 && sb.expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
